[rtl/poea_pkg.sv]
package poea_pkg;

    // angle fixed point: 1/16 degree
    localparam int FRAC_BITS  = 4;
    localparam int ONE_DEG    = 1 << FRAC_BITS;
    localparam int DEG90      = 90 * ONE_DEG;
    localparam int DEG180     = 180 * ONE_DEG;
    localparam int DEG360     = 360 * ONE_DEG;
    localparam int NEAR_STEPS = ONE_DEG / 10;
    localparam int MEAN_MAX   = (1 << 26) - 1;
    localparam int TEST_MAX   = 180;

    // reciprocal for a divide by ten of values up to 90
    localparam int TEN_RECIP  = 205;
    localparam int TEN_SHIFT  = 11;

    // reduction steps: 360 degree multiples 2^7 .. 2^0
    localparam int WRAP_STEPS = 8;
    localparam int DIV_STEPS  = 32;

    localparam logic signed [13:0] PH_180      = 14'(DEG180);
    localparam logic signed [13:0] PH_360      = 14'(DEG360);
    localparam logic signed [13:0] PH_NEAR_LIM = 14'(NEAR_STEPS - DEG180);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_H,
        S_MUL_K,
        S_LOAD,
        S_WRAP,
        S_FOLD,
        S_WMUL,
        S_ACC,
        S_END,
        S_DIV,
        S_BAND
    } t_state;

    typedef enum logic [2:0] {
        CFG_H_SHIFT  = 3'd0,
        CFG_K_SHIFT  = 3'd1,
        CFG_RES_MIN  = 3'd2,
        CFG_RES_MAX  = 3'd3,
        CFG_QUAL_MAX = 3'd4,
        CFG_COUNT    = 3'd5
    } t_cfg_index;

    // operands of the shared multiplier and compare-subtract unit
    typedef struct packed {
        logic signed [14:0] mul_a;
        logic signed [8:0]  mul_b;
        logic [20:0]        sub_a;
        logic [20:0]        sub_b;
    } t_alu_req;

    typedef struct packed {
        logic signed [23:0] prod;
        logic               ge;
        logic [20:0]        rem;
    } t_alu_rsp;

endpackage

[rtl/poea_alu.sv]
module poea_alu
    import poea_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [20:0] diff;

    assign diff        = i_req.sub_a - i_req.sub_b;
    assign o_rsp.prod  = 24'(i_req.mul_a * i_req.mul_b);
    assign o_rsp.ge    = (i_req.sub_a >= i_req.sub_b);
    // conditional subtract: keep the operand when it is below the subtrahend
    assign o_rsp.rem   = o_rsp.ge ? diff : i_req.sub_a;

endmodule

[rtl/phase_origin_error_accumulator_unit.sv]
// Phase origin error accumulator. Scores one trial phase origin over a stream of
// reflections: every reflection inside the quality limit and resolution window is
// shifted by h*origin_h_shift + k*origin_k_shift; a weight >= 1.0 adds the weighted
// absolute wrapped difference to the reference phase, and a symmetry-constrained
// reflection adds its distance (folded into 0..90 degrees) from the test phase. The
// sum saturates at 2^32-1. The item marked last_item yields one result: the sum
// divided by comparison_count (undivided when it is 0), saturated to 26 bits, with
// its band trunc((90 - mean in degrees)/10), and the sum is cleared. Angles are in
// 1/16 degree, the test phase in whole degrees. One item at a time: o_stall is high
// while an item is in work, and a last item also waits for the output register to free.
// The multiplies and the wrap and division steps share the one multiplier and
// compare-subtract unit: each phase wrap takes away a power-of-two multiple of 360
// degrees per cycle, from 2^7 down to 2^0, and the mean is a restoring division
// producing one quotient bit per cycle.
// Configuration is written through a separate port that is always ready; write it
// only while the block is idle.
module phase_origin_error_accumulator_unit
    import poea_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [13:0]        i_cfg_data,

    // reflection input
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [6:0]  i_h_index,
    input  logic signed [6:0]  i_k_index,
    input  logic [3:0]         i_spot_quality,
    input  logic [11:0]        i_resolution,
    input  logic signed [13:0] i_input_phase,
    input  logic signed [13:0] i_reference_phase,
    input  logic [7:0]         i_weight,
    input  logic               i_special_flag,
    input  logic [7:0]         i_test_phase,
    input  logic               i_last_item,

    // result output
    output logic               o_valid,
    input  logic               i_stall,
    output logic [25:0]        o_mean_error,
    output logic [3:0]         o_error_band
);

    // configuration registers
    logic signed [13:0] r_h_shift;
    logic signed [13:0] r_k_shift;
    logic [11:0]        r_res_min;
    logic [11:0]        r_res_max;
    logic [3:0]         r_quality_max;
    logic [12:0]        r_count;

    // sequencer and accumulator state
    t_state             r_state, n_state;
    logic [31:0]        r_sum, n_sum;
    logic [4:0]         r_cnt, n_cnt;

    // captured reflection
    logic signed [6:0]  r_h, n_h;
    logic signed [6:0]  r_k, n_k;
    logic signed [13:0] r_phi, n_phi;
    logic signed [13:0] r_phr, n_phr;
    logic [7:0]         r_weight, n_weight;
    logic               r_special, n_special;
    logic [7:0]         r_test, n_test;
    logic               r_last, n_last;

    // datapath working registers
    logic signed [21:0] r_p, n_p;        // shifted phase
    logic [20:0]        r_mag, n_mag;    // magnitude under reduction
    logic               r_neg, n_neg;    // sign of the value being wrapped
    logic               r_sel, n_sel;    // 0: weighted difference, 1: symmetry term
    logic [11:0]        r_d, n_d;        // absolute wrapped difference
    logic [15:0]        r_term, n_term;  // term to accumulate
    logic [12:0]        r_rem, n_rem;    // division remainder

    // output register
    logic               r_o_valid, n_o_valid;
    logic [25:0]        r_mean, n_mean;
    logic [3:0]         r_band, n_band;

    // shared unit
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    // combinational helpers
    logic               in_pass;
    logic               weighted;
    logic signed [22:0] wrap_in;
    logic signed [13:0] wf;
    logic [11:0]        ang;
    logic [7:0]         test_sat;
    logic [11:0]        test_ph;
    logic [11:0]        sym_d;
    logic [13:0]        rem_sh;
    logic [32:0]        sum_ext;
    logic [25:0]        mean_sat;
    logic [6:0]         up_deg;
    logic [6:0]         band_x;
    logic [14:0]        band_prod;
    logic [3:0]         band_val;

    poea_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_mean_error = r_mean;
    assign o_error_band = r_band;

    // configuration write, out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_shift     <= '0;
            r_k_shift     <= '0;
            r_res_min     <= '0;
            r_res_max     <= '1;
            r_quality_max <= '1;
            r_count       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_H_SHIFT:  r_h_shift     <= i_cfg_data;
                CFG_K_SHIFT:  r_k_shift     <= i_cfg_data;
                CFG_RES_MIN:  r_res_min     <= i_cfg_data[11:0];
                CFG_RES_MAX:  r_res_max     <= i_cfg_data[11:0];
                CFG_QUAL_MAX: r_quality_max <= i_cfg_data[3:0];
                CFG_COUNT:    r_count       <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_o_valid <= n_o_valid;
        end
    end

    // payload and working registers need no reset
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_h       <= n_h;
        r_k       <= n_k;
        r_phi     <= n_phi;
        r_phr     <= n_phr;
        r_weight  <= n_weight;
        r_special <= n_special;
        r_test    <= n_test;
        r_last    <= n_last;
        r_p       <= n_p;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_sel     <= n_sel;
        r_d       <= n_d;
        r_term    <= n_term;
        r_rem     <= n_rem;
        r_mean    <= n_mean;
        r_band    <= n_band;
    end

    always_comb begin
        n_state   = r_state;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_h       = r_h;
        n_k       = r_k;
        n_phi     = r_phi;
        n_phr     = r_phr;
        n_weight  = r_weight;
        n_special = r_special;
        n_test    = r_test;
        n_last    = r_last;
        n_p       = r_p;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_sel     = r_sel;
        n_d       = r_d;
        n_term    = r_term;
        n_rem     = r_rem;
        n_o_valid = r_o_valid;
        n_mean    = r_mean;
        n_band    = r_band;
        alu_req   = '0;

        // quality and resolution window of the incoming reflection
        in_pass  = (i_spot_quality <= r_quality_max) && (i_resolution >= r_res_min)
                   && (i_resolution <= r_res_max);
        weighted = (r_weight >= 8'(ONE_DEG));

        // value to wrap: shifted phase, or its difference to the reference
        wrap_in  = r_sel ? {r_p[21], r_p}
                         : ({r_p[21], r_p} - {{9{r_phr[13]}}, r_phr});

        // remainder with the dividend's sign, folded into (-180,180]
        wf = r_neg ? -$signed(r_mag[13:0]) : $signed(r_mag[13:0]);
        if (wf > PH_180) begin
            wf = wf - PH_360;
        end
        if (wf <= -PH_180) begin
            wf = wf + PH_360;
        end
        if (wf <= PH_NEAR_LIM) begin
            wf = PH_180;
        end
        ang = wf[13] ? 12'(-wf) : wf[11:0];

        // symmetry term: distance to test phase, folded into 0..90 degrees
        test_sat = (r_test > 8'(TEST_MAX)) ? 8'(TEST_MAX) : r_test;
        test_ph  = 12'(test_sat) << FRAC_BITS;
        sym_d    = (ang >= test_ph) ? (ang - test_ph) : (test_ph - ang);
        if (sym_d > 12'(DEG90)) begin
            sym_d = 12'(DEG180) - sym_d;
        end

        // saturating accumulate
        sum_ext  = {1'b0, r_sum} + 33'(r_term);

        // division step operand: remainder with next dividend bit
        rem_sh   = {r_rem, r_sum[31]};

        // mean saturation and band
        mean_sat  = (r_sum > 32'(MEAN_MAX)) ? 26'(MEAN_MAX) : r_sum[25:0];
        up_deg    = 7'((mean_sat[10:0] + 11'(ONE_DEG - 1)) >> FRAC_BITS);
        band_x    = 7'd90 - up_deg;
        band_prod = 15'(band_x) * 15'(TEN_RECIP);
        band_val  = (mean_sat >= 26'(DEG90)) ? 4'd0 : band_prod[TEN_SHIFT +: 4];

        // output register frees on a transfer
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_h       = i_h_index;
                    n_k       = i_k_index;
                    n_phi     = i_input_phase;
                    n_phr     = i_reference_phase;
                    n_weight  = i_weight;
                    n_special = i_special_flag;
                    n_test    = i_test_phase;
                    n_last    = i_last_item;
                    n_state   = in_pass ? S_MUL_H : S_END;
                end
            end
            S_MUL_H: begin
                alu_req.mul_a = {r_h_shift[13], r_h_shift};
                alu_req.mul_b = {{2{r_h[6]}}, r_h};
                n_p     = {{8{r_phi[13]}}, r_phi} + alu_rsp.prod[21:0];
                n_state = S_MUL_K;
            end
            S_MUL_K: begin
                alu_req.mul_a = {r_k_shift[13], r_k_shift};
                alu_req.mul_b = {{2{r_k[6]}}, r_k};
                n_p   = r_p + alu_rsp.prod[21:0];
                n_sel = !weighted;
                if (weighted || r_special) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_END;
                end
            end
            S_LOAD: begin
                n_neg   = wrap_in[22];
                n_mag   = wrap_in[22] ? 21'(-wrap_in) : wrap_in[20:0];
                n_cnt   = 5'(WRAP_STEPS - 1);
                n_state = S_WRAP;
            end
            S_WRAP: begin
                // take away 360 degrees times 2^cnt when it fits
                alu_req.sub_a = r_mag;
                alu_req.sub_b = 21'(DEG360) << r_cnt[2:0];
                n_mag = alu_rsp.rem;
                if (r_cnt == 5'd0) begin
                    n_state = S_FOLD;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_FOLD: begin
                if (!r_sel) begin
                    n_d     = ang;
                    n_state = S_WMUL;
                end else begin
                    n_term  = 16'(sym_d);
                    n_state = S_ACC;
                end
            end
            S_WMUL: begin
                alu_req.mul_a = {3'b000, r_d};
                alu_req.mul_b = {1'b0, r_weight};
                n_term  = alu_rsp.prod[FRAC_BITS +: 16];
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum = sum_ext[32] ? '1 : sum_ext[31:0];
                if (!r_sel && r_special) begin
                    n_sel   = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_count == '0) begin
                    n_state = S_BAND;
                end else begin
                    n_rem   = '0;
                    n_cnt   = 5'(DIV_STEPS - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, quotient shifts into the sum register
                alu_req.sub_a = 21'(rem_sh);
                alu_req.sub_b = 21'(r_count);
                n_rem = alu_rsp.rem[12:0];
                n_sum = {r_sum[30:0], alu_rsp.ge};
                if (r_cnt == 5'd0) begin
                    n_state = S_BAND;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_BAND: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_mean    = mean_sat;
                    n_band    = band_val;
                    n_sum     = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // wrap reduction leaves less than one full turn
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FOLD |-> r_mag < 21'(DEG360))
        else $error("wrap reduction out of range");

    // partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_count)
        else $error("division remainder not below divisor");

    // sum is cleared once a result is loaded
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BAND && n_state == S_IDLE) |=> r_sum == '0)
        else $error("error sum not cleared after result");

    // a result appears only from the band step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_BAND)
        else $error("result without band step");

    // band is never above nine
    a_band_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_error_band <= 4'd9)
        else $error("error band out of range");
`endif

endmodule
